[hw/rtl/ascii_command_frame_parser_macros.svh]
// Assertion macros shared by the frame parser RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n
// in the module that uses it.
`ifndef ASCII_COMMAND_FRAME_PARSER_MACROS_SVH
`define ASCII_COMMAND_FRAME_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define ACFP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ACFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ACFP_ASSERT_SAME(label, ante, cons, msg)
`define ACFP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[hw/rtl/acfp_pkg.sv]
package acfp_pkg;

	localparam int BUF_DEPTH = 8;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);

	// Write index positions that matter to the buffer.
	localparam logic [3:0] IDX_FIRST_DATA = 4'd1;
	localparam logic [3:0] IDX_BUF_END    = 4'd8;
	localparam logic [3:0] IDX_LAST       = 4'd9;

	localparam logic [7:0] CHAR_CR   = 8'd13;
	localparam logic [7:0] CHAR_ZERO = 8'd48;
	localparam logic [7:0] CHAR_HALT = 8'h6F; // 'o'
	localparam logic [7:0] CHAR_R_UP = 8'h52; // 'R'
	localparam logic [7:0] CHAR_G_UP = 8'h47; // 'G'
	localparam logic [7:0] CHAR_R_LO = 8'h72; // 'r'
	localparam logic [7:0] CHAR_G_LO = 8'h67; // 'g'
	localparam logic [7:0] CHAR_BANG = 8'h21; // '!'
	localparam logic [7:0] CHAR_K_UP = 8'h4B; // 'K'
	localparam logic [7:0] CHAR_K_LO = 8'h6B; // 'k'
	localparam logic [7:0] CHAR_AT   = 8'h40; // '@'
	localparam logic [7:0] CHAR_Z_LO = 8'h7A; // 'z'

	localparam logic [1:0] KIND_UNKNOWN = 2'd0;
	localparam logic [1:0] KIND_PAIR    = 2'd1;
	localparam logic [1:0] KIND_HALT    = 2'd2;

	typedef struct packed {
		logic       hit;
		logic [3:0] slot;
	} slot_info_t;

	// Byte held in the input register, as seen by the frame state.
	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
		logic       line_error;
	} step_t;

	typedef struct packed {
		logic [1:0]  frame_kind;
		logic [3:0]  slot;
		logic [15:0] first_value;
		logic [15:0] second_value;
		logic        halt;
	} result_t;

	function automatic slot_info_t pair_slot(input logic [7:0] c);
		slot_info_t info;
		info.hit  = 1'b1;
		info.slot = 4'd0;
		case (c)
			CHAR_R_UP: info.slot = 4'd0;
			CHAR_G_UP: info.slot = 4'd1;
			CHAR_R_LO: info.slot = 4'd2;
			CHAR_G_LO: info.slot = 4'd3;
			CHAR_BANG: info.slot = 4'd4;
			CHAR_K_UP: info.slot = 4'd5;
			CHAR_K_LO: info.slot = 4'd6;
			CHAR_AT:   info.slot = 4'd7;
			CHAR_Z_LO: info.slot = 4'd8;
			default:   info.hit  = 1'b0;
		endcase
		return info;
	endfunction

	// Three characters as a decimal number; everything wraps at 16 bits.
	function automatic logic [15:0] decode3(input logic [7:0] d2, input logic [7:0] d1,
			input logic [7:0] d0);
		logic [15:0] h;
		logic [15:0] t;
		logic [15:0] u;
		h = {8'd0, d2} - {8'd0, CHAR_ZERO};
		t = {8'd0, d1} - {8'd0, CHAR_ZERO};
		u = {8'd0, d0} - {8'd0, CHAR_ZERO};
		return 16'(h * 16'd100) + 16'(t * 16'd10) + u;
	endfunction

endpackage

[hw/rtl/acfp_in_if.sv]
interface acfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       line_error;

	modport source (output valid, output rx_byte, output line_error, input ready);
	modport sink (input valid, input rx_byte, input line_error, output ready);
endinterface

[hw/rtl/acfp_out_if.sv]
interface acfp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_kind;
	logic [3:0]  slot;
	logic [15:0] first_value;
	logic [15:0] second_value;
	logic        halt;

	modport source (output valid, output frame_kind, output slot, output first_value,
		output second_value, output halt, input ready);
	modport sink (input valid, input frame_kind, input slot, input first_value,
		input second_value, input halt, output ready);
endinterface

[hw/rtl/acfp_frame_state.sv]
module acfp_frame_state (
	input  logic             clk,
	input  logic             arst_n,
	input  acfp_pkg::step_t  step,
	input  logic             commit,
	output logic             emit,
	output acfp_pkg::result_t res
);
	import acfp_pkg::*;

	logic [7:0] buf_q [BUF_DEPTH];
	logic [3:0] idx_q;
	logic       halt_q;

	slot_info_t hdr_info;
	slot_info_t in_info;
	logic       is_header;
	logic       is_cr;

	always_comb begin
		hdr_info  = pair_slot(buf_q[0]);
		in_info   = pair_slot(step.rx_byte);
		is_header = in_info.hit || (step.rx_byte == CHAR_HALT);
		is_cr     = (step.rx_byte == CHAR_CR);
		emit      = step.valid && !step.line_error && !is_header && is_cr;

		res = '0;
		res.halt = halt_q;
		if (hdr_info.hit) begin
			res.frame_kind   = KIND_PAIR;
			res.slot         = hdr_info.slot;
			res.first_value  = decode3(buf_q[1], buf_q[2], buf_q[3]);
			res.second_value = decode3(buf_q[5], buf_q[6], buf_q[7]);
			res.halt         = 1'b0;
		end else if (buf_q[0] == CHAR_HALT) begin
			res.frame_kind = KIND_HALT;
			res.halt       = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUF_DEPTH; i++) begin
				buf_q[i] <= '0;
			end
			idx_q  <= '0;
			halt_q <= 1'b0;
		end else if (commit && !step.line_error) begin
			if (is_header) begin
				buf_q[0] <= step.rx_byte;
				idx_q    <= IDX_FIRST_DATA;
			end else if (!is_cr) begin
				// Positions past the end of the buffer are counted but not stored.
				if (idx_q < IDX_BUF_END) begin
					buf_q[idx_q[BUF_AW-1:0]] <= step.rx_byte;
				end
				idx_q <= (idx_q >= IDX_LAST) ? 4'd0 : idx_q + 4'd1;
			end else begin
				halt_q <= res.halt;
			end
		end
	end

endmodule

[hw/rtl/acfp_out_reg.sv]
module acfp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  acfp_pkg::result_t res,
	output logic              free,
	acfp_out_if.source        frame
);
	import acfp_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free = !valid_q || frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (frame.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign frame.valid        = valid_q;
	assign frame.frame_kind   = data_q.frame_kind;
	assign frame.slot         = data_q.slot;
	assign frame.first_value  = data_q.first_value;
	assign frame.second_value = data_q.second_value;
	assign frame.halt         = data_q.halt;

endmodule

[hw/rtl/ascii_command_frame_parser.sv]
// Channel  Dir  Payload                                            Handshake
// rx       in   rx_byte[7:0], line_error                           valid/ready
// frame    out  frame_kind[1:0], slot[3:0], first_value[15:0],     valid/ready
//               second_value[15:0], halt
//
// One received byte is taken every cycle unless a carriage return is blocked; a
// carriage return's frame passes the input register and then the result register.
// The frame buffer and the decimal decode sit in one stage between those registers.
// arst_n clears the buffer, write index, halt flag and both valid bits at once.
// A result held by frame.ready low stalls a waiting carriage return; other bytes
// still pass, and rx.ready falls only when such a return is blocked.
`include "ascii_command_frame_parser_macros.svh"

module ascii_command_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	acfp_in_if.sink     rx,
	acfp_out_if.source  frame
);
	import acfp_pkg::*;

	// Input register: holds one received byte request.
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       line_error_s1;

	step_t   step;
	logic    emit;
	logic    out_free;
	logic    advance;
	result_t res;

	assign step.valid      = valid_s1;
	assign step.rx_byte    = rx_byte_s1;
	assign step.line_error = line_error_s1;

	// A byte that makes no frame always leaves the input register; a carriage
	// return waits until the result register can take its frame.
	assign advance  = valid_s1 && (!emit || out_free);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1    <= rx.rx_byte;
			line_error_s1 <= rx.line_error;
		end
	end

	// Frame buffer, write index and halt flag; decodes the frame on a return.
	acfp_frame_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.commit (advance),
		.emit   (emit),
		.res    (res)
	);

	// Result register, which lets input continue while a frame waits.
	acfp_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && emit),
		.res    (res),
		.free   (out_free),
		.frame  (frame)
	);

	// A held frame is never overwritten by a new one.
	`ACFP_ASSERT_SAME(a_no_overwrite, frame.valid && !frame.ready, !(advance && emit), "frame overwritten while stalled")
	// Only value pair frames carry a slot and values.
	`ACFP_ASSERT_SAME(a_plain_zero, frame.valid && frame.frame_kind != KIND_PAIR, frame.slot == 4'd0 && frame.first_value == 16'd0 && frame.second_value == 16'd0, "non-pair frame carries data")
	// The halt flag follows the frame that set or cleared it.
	`ACFP_ASSERT_SAME(a_halt_kind, frame.valid && (frame.frame_kind == KIND_HALT || frame.frame_kind == KIND_PAIR), frame.halt == (frame.frame_kind == KIND_HALT), "halt flag disagrees with frame kind")
	// A loaded frame is presented in the next cycle.
	`ACFP_ASSERT_NEXT(a_load_shows, advance && emit, frame.valid, "loaded frame not presented")

endmodule

[bench/tb_ascii_command_frame_parser.sv]
module tb_ascii_command_frame_parser;
	import acfp_pkg::*;

	// One received byte as the driver sends it. A request marked hold_off is not
	// offered until every frame already predicted has come out of the parser.
	typedef struct packed {
		logic [7:0] code;
		logic       err;
		logic       hold_off;
	} rx_req_t;

	logic clk;
	logic arst_n;

	acfp_in_if  rx_bus ();
	acfp_out_if frame_bus ();

	ascii_command_frame_parser DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_bus),
		.frame  (frame_bus)
	);

	// Requests waiting to be driven, and frames predicted but not yet seen.
	rx_req_t rx_requests[$];
	result_t frames_due[$];
	int      mismatches;

	// Our own copy of the parser state, updated at every accepted request.
	logic [7:0] frame_copy [BUF_DEPTH];
	logic [3:0] wr_pos;
	logic       halt_copy;

	// Idle control for both sides. A calm flag turns off idling for a stretch.
	int unsigned send_gap;
	bit          send_calm;
	int unsigned sink_stall;
	bit          sink_calm;

	always #5 clk = ~clk;

	// Slot number of a value-pair header, or -1 when the byte is not one.
	function automatic int header_slot(input logic [7:0] c);
		case (c)
			CHAR_R_UP: return 0;
			CHAR_G_UP: return 1;
			CHAR_R_LO: return 2;
			CHAR_G_LO: return 3;
			CHAR_BANG: return 4;
			CHAR_K_UP: return 5;
			CHAR_K_LO: return 6;
			CHAR_AT:   return 7;
			CHAR_Z_LO: return 8;
			default:   return -1;
		endcase
	endfunction

	// True for any byte that starts a frame or closes one.
	function automatic bit is_marker(input logic [7:0] c);
		return c == CHAR_CR || c == CHAR_HALT || header_slot(c) >= 0;
	endfunction

	// Three buffer bytes read as decimal digits. The sum is taken in 32-bit
	// unsigned arithmetic, which keeps the low 16 bits exact when it wraps.
	function automatic logic [15:0] digits_value(input logic [7:0] hi, input logic [7:0] mid,
			input logic [7:0] lo);
		int unsigned acc;
		acc = 100 * ({24'd0, hi} - {24'd0, CHAR_ZERO})
			+ 10 * ({24'd0, mid} - {24'd0, CHAR_ZERO})
			+ ({24'd0, lo} - {24'd0, CHAR_ZERO});
		return acc[15:0];
	endfunction

	// Applies one accepted byte to the state copy. A carriage return adds the
	// frame it closes to the list of frames due.
	task automatic predict_rx_byte(input logic [7:0] c, input logic err);
		int      hs;
		result_t want;
		if (err) begin
			return;
		end
		if (is_marker(c) && c != CHAR_CR) begin
			frame_copy[0] = c;
			wr_pos = IDX_FIRST_DATA;
			return;
		end
		if (c != CHAR_CR) begin
			// Positions eight and nine lie past the buffer; the byte is lost there.
			if (wr_pos < IDX_BUF_END) begin
				frame_copy[wr_pos[BUF_AW-1:0]] = c;
			end
			wr_pos = (wr_pos >= IDX_LAST) ? 4'd0 : wr_pos + 4'd1;
			return;
		end
		hs = header_slot(frame_copy[0]);
		want = '0;
		want.frame_kind = KIND_UNKNOWN;
		if (hs >= 0) begin
			halt_copy = 1'b0;
			want.frame_kind = KIND_PAIR;
			want.slot = hs[3:0];
			want.first_value = digits_value(frame_copy[1], frame_copy[2], frame_copy[3]);
			want.second_value = digits_value(frame_copy[5], frame_copy[6], frame_copy[7]);
		end else if (frame_copy[0] == CHAR_HALT) begin
			halt_copy = 1'b1;
			want.frame_kind = KIND_HALT;
		end
		want.halt = halt_copy;
		frames_due.push_back(want);
	endtask

	// Mostly back to back, sometimes a short gap, now and then a long pause.
	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_rx(input logic [7:0] code, input logic err, input logic hold_off);
		rx_req_t req;
		req.code = code;
		req.err = err;
		req.hold_off = hold_off;
		rx_requests.push_back(req);
	endtask

	task automatic queue_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			queue_rx(8'(s[i]), 1'b0, 1'b0);
		end
	endtask

	function automatic logic [7:0] random_header();
		case ($urandom_range(0, 9))
			0: return CHAR_R_UP;
			1: return CHAR_G_UP;
			2: return CHAR_R_LO;
			3: return CHAR_G_LO;
			4: return CHAR_BANG;
			5: return CHAR_K_UP;
			6: return CHAR_K_LO;
			7: return CHAR_AT;
			8: return CHAR_Z_LO;
			default: return CHAR_HALT;
		endcase
	endfunction

	// Any byte that neither starts nor closes a frame.
	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (is_marker(c));
		return c;
	endfunction

	// Adds one random group of requests. Most are well-formed frames with
	// random digits; the rest are line noise and cut-off frames.
	task automatic add_random_frame(input bit hold_first);
		int         pick;
		int         len;
		int         i;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			queue_rx(random_header(), 1'b0, hold_first);
			// Some frames run short or long; a long one reaches the end of the
			// buffer, wraps and overwrites the header.
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : 7;
			for (i = 1; i <= len; i++) begin
				if ($urandom_range(0, 19) == 0) begin
					queue_rx(8'($urandom_range(0, 255)), 1'b1, 1'b0);
				end
				if (i == 4) begin
					c = $urandom_range(0, 1) ? 8'h20 : 8'h2C;
				end else if ($urandom_range(0, 6) != 0) begin
					c = CHAR_ZERO + 8'($urandom_range(0, 9));
				end else begin
					c = plain_byte();
				end
				queue_rx(c, 1'b0, 1'b0);
			end
			if ($urandom_range(0, 29) == 0) begin
				queue_rx(CHAR_CR, 1'b1, 1'b0);
			end
			queue_rx(CHAR_CR, 1'b0, 1'b0);
		end else if (pick < 90) begin
			len = $urandom_range(1, 6);
			for (i = 0; i < len; i++) begin
				queue_rx(8'($urandom_range(0, 255)), 1'($urandom_range(0, 9) == 0),
					1'(i == 0 && hold_first));
			end
		end else begin
			queue_rx(random_header(), 1'($urandom_range(0, 3) == 0), hold_first);
			len = $urandom_range(0, 3);
			for (i = 0; i < len; i++) begin
				queue_rx(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
			queue_rx(CHAR_CR, 1'b0, 1'b0);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Driver. The prediction for an accepted byte is made here, before the next
	// request is chosen, so that a hold-off sees every frame already due.
	always @(posedge clk) begin
		rx_req_t req;
		if (!arst_n) begin
			rx_bus.valid <= 1'b0;
		end else begin
			if (rx_bus.valid && rx_bus.ready) begin
				predict_rx_byte(rx_bus.rx_byte, rx_bus.line_error);
			end
			if (!rx_bus.valid || rx_bus.ready) begin
				if (send_gap != 0) begin
					send_gap--;
					rx_bus.valid <= 1'b0;
				end else if (rx_requests.size() == 0
						|| (rx_requests[0].hold_off && frames_due.size() != 0)) begin
					rx_bus.valid <= 1'b0;
				end else begin
					req = rx_requests.pop_front();
					rx_bus.valid <= 1'b1;
					rx_bus.rx_byte <= req.code;
					rx_bus.line_error <= req.err;
					send_gap = pick_gap(send_calm);
					if ($urandom_range(0, 63) == 0) begin
						send_calm = !send_calm;
					end
				end
			end
		end
	end

	// The frame side stalls at random; a stalled carriage return must hold
	// back the byte stream behind it.
	always @(posedge clk) begin
		if (!arst_n) begin
			frame_bus.ready <= 1'b0;
		end else if (sink_stall != 0) begin
			sink_stall--;
			frame_bus.ready <= 1'b0;
		end else begin
			frame_bus.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				sink_stall = pick_gap(sink_calm);
			end
			if ($urandom_range(0, 199) == 0) begin
				sink_calm = !sink_calm;
			end
		end
	end

	// Monitor. Every accepted frame is matched with the oldest one due.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && frame_bus.valid && frame_bus.ready) begin
			if (frames_due.size() == 0) begin
				$display("%0t: frame with none due, expected nothing, got kind %0d slot %0d",
					$time, frame_bus.frame_kind, frame_bus.slot);
				mismatches++;
			end else begin
				want = frames_due.pop_front();
				check_field("frame_kind", 16'(want.frame_kind), 16'(frame_bus.frame_kind));
				check_field("slot", 16'(want.slot), 16'(frame_bus.slot));
				check_field("first_value", want.first_value, frame_bus.first_value);
				check_field("second_value", want.second_value, frame_bus.second_value);
				check_field("halt", 16'(want.halt), 16'(frame_bus.halt));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("ascii_command_frame_parser test failed");
		$finish;
	end

	initial begin
		int i;
		clk = 1'b0;
		arst_n = 1'b0;
		rx_bus.valid = 1'b0;
		rx_bus.rx_byte = 8'd0;
		rx_bus.line_error = 1'b0;
		frame_bus.ready = 1'b0;
		mismatches = 0;
		send_gap = 0;
		send_calm = 1'b0;
		sink_stall = 0;
		sink_calm = 1'b0;
		for (i = 0; i < BUF_DEPTH; i++) begin
			frame_copy[i] = 8'd0;
		end
		wr_pos = 4'd0;
		halt_copy = 1'b0;

		// A carriage return straight after reset meets an all-zero buffer.
		queue_rx(CHAR_CR, 1'b0, 1'b0);
		// A halt command sets the halt flag.
		queue_rx(CHAR_HALT, 1'b0, 1'b0);
		queue_rx(CHAR_CR, 1'b0, 1'b0);
		// A value pair at the digit extremes clears halt again. The carriage
		// return with a line error in the middle must be dropped.
		queue_rx(CHAR_Z_LO, 1'b0, 1'b0);
		queue_text("999");
		queue_rx(CHAR_CR, 1'b1, 1'b0);
		queue_text(" 000");
		queue_rx(CHAR_CR, 1'b0, 1'b0);
		// An overlong frame with byte extremes: the bytes at positions eight and
		// nine are lost, the index wraps and the next byte replaces the header,
		// so the frame comes out unknown.
		queue_rx(CHAR_K_UP, 1'b0, 1'b0);
		queue_rx(8'h00, 1'b0, 1'b0);
		queue_rx(8'hFF, 1'b0, 1'b0);
		queue_text("12345");
		queue_rx(8'hAA, 1'b0, 1'b0);
		queue_rx(8'h55, 1'b0, 1'b0);
		queue_rx(8'hFF, 1'b0, 1'b0);
		queue_rx(CHAR_CR, 1'b0, 1'b0);

		// The first random frame always waits for the parser to drain.
		add_random_frame(1'b1);
		while (rx_requests.size() < 1725) begin
			add_random_frame(1'($urandom_range(0, 24) == 0));
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_requests.size() != 0 || rx_bus.valid) begin
			@(posedge clk);
		end
		while (frames_due.size() != 0) begin
			@(posedge clk);
		end
		// Let any stray frame surface before the verdict.
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("ascii_command_frame_parser test passed");
		end else begin
			$display("ascii_command_frame_parser test failed");
		end
		$finish;
	end

endmodule
